FILE: rtl/csis_pkg.sv
`default_nettype none
// Shared types, character codes and helpers for the include scanner.
package csis_pkg;

    // Width of the byte position counter and of the reported fields
    localparam int OFFSET_BITS = 24;
    localparam int OUT_BITS    = 24;

    typedef logic [OFFSET_BITS-1:0] pos_t;
    typedef logic [OUT_BITS-1:0]    out_field_t;

    localparam pos_t POS_MAX = {OFFSET_BITS{1'b1}};

    // ASCII codes the scanner looks for
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_E  = 8'h65;

    // One source byte as held in the input register
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } item_t;

    // One found include name
    typedef struct packed {
        out_field_t name_offset;
        out_field_t name_length;
    } result_t;

    // Handshake between scanner core and result register
    typedef struct packed {
        logic hit;
        logic consume;
    } core_ctrl_t;

    // Advance a position, holding at the top value
    function automatic pos_t pos_inc(input pos_t p);
        pos_t r;
        r = (p == POS_MAX) ? POS_MAX : p + pos_t'(1);
        return r;
    endfunction

    // Fit a position to the output field width
    function automatic out_field_t to_out(input pos_t p);
        out_field_t r;
        r = OUT_BITS'(p);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/c_source_include_scanner.sv
`default_nettype none
// Top level of the C source include scanner.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | text_byte[7:0], final_byte
//  out     | output    | out_valid/out_stall| name_offset[23:0], name_length[23:0]
//
// One byte per cycle unless a closing byte waits on a stalled result register:
// each byte passes the input register and one state transition in the scanner
// core; a closing quote's result goes on into the result register, which drives out_valid.
// The rate is set by the registered scanner state update.
// Reset (rst_n low) clears scan state, byte position and both valid flags.
// While a result waits under out_stall, bytes that give no result still
// move on; a byte that closes a name waits in the input register.
module c_source_include_scanner
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             text_byte,
    input  wire logic                   final_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output csis_pkg::out_field_t        name_offset,
    output csis_pkg::out_field_t        name_length
);
    import csis_pkg::*;

    logic       item_vld;
    item_t      item;
    logic       out_free;
    core_ctrl_t ctrl;
    result_t    result;

    csis_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .consume    (ctrl.consume),
        .item_vld   (item_vld),
        .item       (item)
    );

    csis_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .item     (item),
        .out_free (out_free),
        .ctrl     (ctrl),
        .result   (result)
    );

    csis_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .result      (result),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .name_offset (name_offset),
        .name_length (name_length)
    );

endmodule

`default_nettype wire

FILE: rtl/csis_in_reg.sv
`default_nettype none
// Input register: holds one source byte until the scanner core takes it.
module csis_in_reg
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      text_byte,
    input  wire logic            final_byte,
    input  wire logic            consume,
    output logic                 item_vld,
    output csis_pkg::item_t      item
);
    import csis_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    logic  accept;

    // Stall only while a held byte cannot move on this cycle
    assign in_stall = vld_reg && !consume;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (consume)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load payload on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.text_byte  <= text_byte;
            item_reg.final_byte <= final_byte;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

FILE: rtl/csis_core.sv
`default_nettype none
// Scanner core: lexical state machine, byte position and name start.
module csis_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_vld,
    input  wire csis_pkg::item_t   item,
    input  wire logic              out_free,
    output csis_pkg::core_ctrl_t   ctrl,
    output csis_pkg::result_t      result
);
    import csis_pkg::*;

    typedef enum logic [4:0] {
        ST_NORMAL      = 5'd0,
        ST_SLASH       = 5'd1,
        ST_STRING      = 5'd2,
        ST_STRING_ESC  = 5'd3,
        ST_CHAR        = 5'd4,
        ST_CHAR_ESC    = 5'd5,
        ST_COMMENT     = 5'd6,
        ST_COMMENT_END = 5'd7,
        ST_PREPROC     = 5'd8,
        ST_SKIP        = 5'd9,
        ST_SKIP_ESC    = 5'd10,
        ST_KW_I        = 5'd11,
        ST_KW_N        = 5'd12,
        ST_KW_C        = 5'd13,
        ST_KW_L        = 5'd14,
        ST_KW_U        = 5'd15,
        ST_KW_D        = 5'd16,
        ST_INC_LINE    = 5'd17,
        ST_INC_NAME    = 5'd18,
        ST_IF_SKIP     = 5'd19
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    pos_t       pos_reg;
    pos_t       pos_next;
    pos_t       begin_reg;
    pos_t       begin_next;
    state_t     normal_ns;
    state_t     skip_ns;
    state_t     comment_ns;
    logic [7:0] c;
    logic       hit;
    logic       consume;
    pos_t       name_len;

    assign c = item.text_byte;

    // Common successor states
    always_comb
    begin
        case (c)
            CH_SLASH: normal_ns = ST_SLASH;
            CH_QUOTE: normal_ns = ST_STRING;
            CH_APOS:  normal_ns = ST_CHAR;
            CH_HASH:  normal_ns = ST_PREPROC;
            default:  normal_ns = ST_NORMAL;
        endcase
        case (c)
            CH_NL:     skip_ns = ST_NORMAL;
            CH_BSLASH: skip_ns = ST_SKIP_ESC;
            default:   skip_ns = ST_SKIP;
        endcase
        comment_ns = (c == CH_STAR) ? ST_COMMENT_END : ST_COMMENT;
    end

    // Length of the name, never below zero
    assign name_len = (pos_reg >= begin_reg) ? pos_reg - begin_reg : '0;

    // Next state, name start and result detection for the held byte
    always_comb
    begin
        state_next = state_reg;
        begin_next = begin_reg;
        hit        = 1'b0;
        case (state_reg)
            ST_SLASH:
            begin
                state_next = (c == CH_STAR) ? ST_COMMENT : normal_ns;
            end
            ST_STRING:
            begin
                state_next = (c == CH_QUOTE)  ? ST_NORMAL :
                             (c == CH_BSLASH) ? ST_STRING_ESC : ST_STRING;
            end
            ST_STRING_ESC:  state_next = ST_STRING;
            ST_CHAR:
            begin
                state_next = (c == CH_APOS)   ? ST_NORMAL :
                             (c == CH_BSLASH) ? ST_CHAR_ESC : ST_CHAR;
            end
            ST_CHAR_ESC:    state_next = ST_CHAR;
            ST_COMMENT:     state_next = comment_ns;
            ST_COMMENT_END:
            begin
                state_next = (c == CH_SLASH) ? ST_NORMAL : comment_ns;
            end
            ST_PREPROC:
            begin
                if (c == CH_NL)
                begin
                    state_next = ST_NORMAL;
                end
                else if (c inside {CH_SPACE, CH_TAB})
                begin
                    state_next = ST_PREPROC;
                end
                else if (c == CH_LOW_I)
                begin
                    state_next = ST_KW_I;
                end
                else
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:        state_next = skip_ns;
            ST_SKIP_ESC:    state_next = ST_SKIP;
            ST_KW_I:
            begin
                state_next = (c == CH_LOW_F) ? ST_IF_SKIP :
                             (c == CH_LOW_N) ? ST_KW_N : skip_ns;
            end
            ST_KW_N:        state_next = (c == CH_LOW_C) ? ST_KW_C : skip_ns;
            ST_KW_C:        state_next = (c == CH_LOW_L) ? ST_KW_L : skip_ns;
            ST_KW_L:        state_next = (c == CH_LOW_U) ? ST_KW_U : skip_ns;
            ST_KW_U:        state_next = (c == CH_LOW_D) ? ST_KW_D : skip_ns;
            ST_KW_D:        state_next = (c == CH_LOW_E) ? ST_INC_LINE : skip_ns;
            ST_INC_LINE:
            begin
                if (c == CH_NL)
                begin
                    state_next = ST_NORMAL;
                end
                else if (c == CH_QUOTE)
                begin
                    state_next = ST_INC_NAME;
                    begin_next = pos_inc(pos_reg);
                end
                else
                begin
                    state_next = ST_INC_LINE;
                end
            end
            ST_INC_NAME:
            begin
                if (c == CH_NL)
                begin
                    state_next = ST_NORMAL;
                end
                else if (c == CH_QUOTE)
                begin
                    state_next = ST_SKIP;
                    hit        = 1'b1;
                end
                else
                begin
                    state_next = ST_INC_NAME;
                end
            end
            ST_IF_SKIP:
            begin
                state_next = (c == CH_NL) ? ST_NORMAL : ST_IF_SKIP;
            end
            default:        state_next = normal_ns;
        endcase
        pos_next = pos_inc(pos_reg);
        // Return to reset after the last byte of a file
        if (item.final_byte)
        begin
            state_next = ST_NORMAL;
            pos_next   = '0;
            begin_next = '0;
        end
    end

    // Take the byte unless its result cannot be placed
    assign consume      = item_vld && (!hit || out_free);
    assign ctrl.consume = consume;
    assign ctrl.hit     = item_vld && hit;

    assign result.name_offset = to_out(begin_reg);
    assign result.name_length = to_out(name_len);

    // Advance scan state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NORMAL;
            pos_reg   <= '0;
            begin_reg <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/csis_out_reg.sv
`default_nettype none
// Result register: holds one found name until downstream takes it.
module csis_out_reg
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire csis_pkg::core_ctrl_t   ctrl,
    input  wire csis_pkg::result_t      result,
    output logic                        out_free,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output csis_pkg::out_field_t        name_offset,
    output csis_pkg::out_field_t        name_length
);
    import csis_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;
    logic    load;

    assign out_free = !vld_reg || !out_stall;
    assign load     = ctrl.hit && ctrl.consume;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // Hold valid until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load a new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid   = vld_reg;
    assign name_offset = res_reg.name_offset;
    assign name_length = res_reg.name_length;

endmodule

`default_nettype wire
